// ===== rtl/wts_pkg.sv =====
package wts_pkg;

  localparam int unsigned MAX_ENTRIES = 16;
  localparam int unsigned ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned REM_W       = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned SUM_W       = TIME_W + REM_W;
  localparam int unsigned STEP_W      = $clog2(TIME_W);

  localparam logic [CNT_W-1:0] CAPACITY_RESET = CNT_W'(10);

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [CNT_W-1:0]  count_t;

  typedef enum logic {
    ACT_RECORD = 1'b0,
    ACT_CLEAR  = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

// ===== rtl/wts_if.sv =====
interface wts_in_if;
  logic          valid;
  logic          ready;
  logic          action;
  wts_pkg::time_t time_value;

  modport source (output valid, output action, output time_value, input ready);
  modport sink   (input valid, input action, input time_value, output ready);
endinterface

interface wts_out_if;
  logic            valid;
  logic            ready;
  wts_pkg::time_t  best_time;
  wts_pkg::time_t  worst_time;
  wts_pkg::time_t  average_time;
  wts_pkg::time_t  latest_time;
  wts_pkg::count_t stored_count;

  modport source (output valid, output best_time, output worst_time, output average_time,
                  output latest_time, output stored_count, input ready);
  modport sink   (input valid, input best_time, input worst_time, input average_time,
                  input latest_time, input stored_count, output ready);
endinterface

// ===== rtl/wts_ram.sv =====
module wts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/window_time_statistics.sv =====
// Sliding-window time statistics. Each input transfer either records a 32-bit time into a
// ring of the last "capacity" times (1 to 16; 0 acts as 1, above 16 acts as 16) or clears
// the window, and produces one result transfer with the minimum, maximum, floor mean and
// latest of the stored times plus their count (all zeros when empty). A record walks the
// single read port of the time memory over its n stored times, takes 32 steps of a
// restoring divider for the mean, loads the result register and returns to idle. A clear
// empties the window and then loads the result register. Both wait to load while the
// previous result has not drained yet. Entries not written since reset or the last clear
// read as zero. The input is not ready while an item is in work; a finished result is
// held in an output register so the next transfer can be taken before it drains. The user
// must write the capacity register through cfg_we_i / cfg_wdata_i only while the block is
// idle; the block itself does not enforce this.
module window_time_statistics (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [wts_pkg::CNT_W-1:0] cfg_wdata_i,
  wts_in_if.sink                in_ch,
  wts_out_if.source             out_ch
);
  import wts_pkg::*;

  state_e state_q, state_d;

  count_t              cap_q;
  count_t              cap_eff;
  logic [ADDR_W-1:0]   ptr_q, ptr_d;
  count_t              count_q, count_d;
  logic [ADDR_W-1:0]   last_idx_q, last_idx_d;
  logic                clr_q, clr_d;
  logic [MAX_ENTRIES-1:0] wr_mask_q, wr_mask_d;

  count_t              iss_q, iss_d;
  logic                rd_vld_q, rd_vld_d;
  count_t              rd_tag_q, rd_tag_d;

  time_t               lo_q, lo_d, hi_q, hi_d, last_q, last_d;
  logic [SUM_W-1:0]    sum_q, sum_d, sum_new;
  logic [REM_W-1:0]    rem_q, rem_d;
  time_t               dq_q, dq_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [REM_W:0]      rem_sh;
  logic [REM_W:0]      div_ext;

  logic                in_fire;
  count_t              slot, slot_nxt;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_raddr;
  time_t               ram_rdata;
  time_t               rd_word;

  logic                out_valid_q, out_valid_d;
  time_t               best_q, best_d, worst_q, worst_d, avg_q, avg_d, lat_q, lat_d;
  count_t              cnt_out_q, cnt_out_d;

  assign in_ch.ready = (state_q == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    priority if (cap_q == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_q > CNT_W'(MAX_ENTRIES)) begin
      cap_eff = CNT_W'(MAX_ENTRIES);
    end else begin
      cap_eff = cap_q;
    end
  end

  assign slot     = (count_t'(ptr_q) < cap_eff) ? count_t'(ptr_q) : '0;
  assign slot_nxt = slot + CNT_W'(1);
  assign ram_we   = in_fire && (in_ch.action == ACT_RECORD);

  wts_ram #(
    .WIDTH (TIME_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot[ADDR_W-1:0]),
    .wdata_i (in_ch.time_value),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ram_raddr = iss_q[ADDR_W-1:0];
  assign rd_word   = wr_mask_q[rd_tag_q[ADDR_W-1:0]] ? ram_rdata : '0;
  assign sum_new   = (rd_tag_q == '0) ? SUM_W'(rd_word) : sum_q + SUM_W'(rd_word);
  assign rem_sh    = {rem_q, dq_q[TIME_W-1]};
  assign div_ext   = (REM_W + 1)'(count_q);

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    count_d     = count_q;
    last_idx_d  = last_idx_q;
    clr_d       = clr_q;
    wr_mask_d   = wr_mask_q;
    iss_d       = iss_q;
    rd_vld_d    = 1'b0;
    rd_tag_d    = rd_tag_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    last_d      = last_q;
    sum_d       = sum_q;
    rem_d       = rem_q;
    dq_d        = dq_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !out_ch.ready;
    best_d      = best_q;
    worst_d     = worst_q;
    avg_d       = avg_q;
    lat_d       = lat_q;
    cnt_out_d   = cnt_out_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          iss_d = '0;
          if (in_ch.action == ACT_CLEAR) begin
            ptr_d     = '0;
            count_d   = '0;
            clr_d     = 1'b1;
            wr_mask_d = '0;
            state_d   = ST_DONE;
          end else begin
            ptr_d      = (slot_nxt >= cap_eff) ? '0 : slot_nxt[ADDR_W-1:0];
            count_d    = (count_q < cap_eff) ? count_q + CNT_W'(1) : cap_eff;
            last_idx_d = (ptr_d == '0) ? ADDR_W'(count_d - CNT_W'(1))
                                       : ptr_d - ADDR_W'(1);
            clr_d      = 1'b0;
            wr_mask_d[slot[ADDR_W-1:0]] = 1'b1;
            state_d    = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (iss_q < count_q) begin
          rd_vld_d = 1'b1;
          rd_tag_d = iss_q;
          iss_d    = iss_q + CNT_W'(1);
        end
        if (rd_vld_q) begin
          sum_d = sum_new;
          if (rd_tag_q == '0) begin
            lo_d = rd_word;
            hi_d = rd_word;
          end else begin
            if (rd_word < lo_q) lo_d = rd_word;
            if (rd_word > hi_q) hi_d = rd_word;
          end
          if (rd_tag_q[ADDR_W-1:0] == last_idx_q) begin
            last_d = rd_word;
          end
          if (rd_tag_q == count_q - CNT_W'(1)) begin
            rem_d   = sum_new[SUM_W-1:TIME_W];
            dq_d    = sum_new[TIME_W-1:0];
            step_d  = '0;
            state_d = ST_DIV;
          end
        end
      end

      ST_DIV: begin
        if (rem_sh >= div_ext) begin
          rem_d = REM_W'(rem_sh - div_ext);
          dq_d  = {dq_q[TIME_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[REM_W-1:0];
          dq_d  = {dq_q[TIME_W-2:0], 1'b0};
        end
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(TIME_W - 1)) begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_q || out_ch.ready) begin
          out_valid_d = 1'b1;
          cnt_out_d   = count_q;
          if (clr_q) begin
            best_d  = '0;
            worst_d = '0;
            avg_d   = '0;
            lat_d   = '0;
          end else begin
            best_d  = lo_q;
            worst_d = hi_q;
            avg_d   = dq_q;
            lat_d   = last_q;
          end
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CAPACITY_RESET;
      ptr_q       <= '0;
      count_q     <= '0;
      clr_q       <= 1'b0;
      wr_mask_q   <= '0;
      iss_q       <= '0;
      rd_vld_q    <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      ptr_q       <= ptr_d;
      count_q     <= count_d;
      clr_q       <= clr_d;
      wr_mask_q   <= wr_mask_d;
      iss_q       <= iss_d;
      rd_vld_q    <= rd_vld_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_idx_q <= last_idx_d;
    rd_tag_q   <= rd_tag_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    last_q     <= last_d;
    sum_q      <= sum_d;
    rem_q      <= rem_d;
    dq_q       <= dq_d;
    best_q     <= best_d;
    worst_q    <= worst_d;
    avg_q      <= avg_d;
    lat_q      <= lat_d;
    cnt_out_q  <= cnt_out_d;
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.best_time    = best_q;
  assign out_ch.worst_time   = worst_q;
  assign out_ch.average_time = avg_q;
  assign out_ch.latest_time  = lat_q;
  assign out_ch.stored_count = cnt_out_q;

endmodule

// ===== rtl/wts_checker.sv =====
module wts_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [wts_pkg::TIME_W-1:0] best_i,
  input logic [wts_pkg::TIME_W-1:0] worst_i,
  input logic [wts_pkg::TIME_W-1:0] avg_i,
  input logic [wts_pkg::TIME_W-1:0] latest_i,
  input logic [wts_pkg::CNT_W-1:0]  count_i
);
  import wts_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transfer");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while an item is in work");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> count_i <= CNT_W'(MAX_ENTRIES))
    else $error("stored count above window size");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (count_i == '0) |->
      (best_i == '0) && (worst_i == '0) && (avg_i == '0) && (latest_i == '0))
    else $error("empty window reports nonzero statistics");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (count_i != '0) |->
      (best_i <= avg_i) && (avg_i <= worst_i) && (best_i <= latest_i) &&
      (latest_i <= worst_i))
    else $error("statistics out of order");

endmodule

bind window_time_statistics wts_checker u_wts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .best_i      (out_ch.best_time),
  .worst_i     (out_ch.worst_time),
  .avg_i       (out_ch.average_time),
  .latest_i    (out_ch.latest_time),
  .count_i     (out_ch.stored_count)
);
